// File: design/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/dpwm_pkg.sv
package dpwm_pkg;

   typedef enum logic [1:0] {
      CSR_MOTOR_DUTY   = 2'd0,
      CSR_FAN_DUTY     = 2'd1,
      CSR_FRAME_TICKS  = 2'd2,
      CSR_STEP_TICKS   = 2'd3
   } dpwm_csr_index_type;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [6:0] DUTY_MIN          = 7'd1;
   localparam logic [6:0] DUTY_MAX          = 7'd99;
   localparam logic [6:0] DUTY_RESET        = 7'd1;
   localparam logic [7:0] FRAME_TICKS_RESET = 8'd156;
   localparam logic [7:0] STEP_TICKS_RESET  = 8'd50;
   localparam logic [7:0] POS_RESET         = 8'd48;

   typedef struct packed {
      logic       action;
      logic [7:0] target_value;
   } dpwm_req_type;

   typedef struct packed {
      logic       motor_pin;
      logic       fan_pin;
      logic       servo_pin;
      logic [7:0] servo_position;
      logic       servo_ready;
   } dpwm_rsp_type;

   typedef struct packed {
      logic [6:0] motor_duty;
      logic [6:0] fan_duty;
      logic [7:0] frame_ticks;
      logic [7:0] step_ticks;
   } dpwm_cfg_type;

endpackage

// File: design/dpwm_csr.sv
module dpwm_csr
   import dpwm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output dpwm_cfg_type           cfg
);

   dpwm_cfg_type cfg_ff;
   dpwm_cfg_type cfg_in;
   logic [6:0]   duty_raw;
   logic [6:0]   duty_clamped;

   always_comb begin
      duty_raw = csr_wdata[6:0];
      if (duty_raw < DUTY_MIN) begin
         duty_clamped = DUTY_MIN;
      end else if (duty_raw > DUTY_MAX) begin
         duty_clamped = DUTY_MAX;
      end else begin
         duty_clamped = duty_raw;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (dpwm_csr_index_type'(csr_index))
            CSR_MOTOR_DUTY:  cfg_in.motor_duty  = duty_clamped;
            CSR_FAN_DUTY:    cfg_in.fan_duty    = duty_clamped;
            CSR_FRAME_TICKS: cfg_in.frame_ticks = csr_wdata;
            CSR_STEP_TICKS:  cfg_in.step_ticks  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_duty  <= DUTY_RESET;
         cfg_ff.fan_duty    <= DUTY_RESET;
         cfg_ff.frame_ticks <= FRAME_TICKS_RESET;
         cfg_ff.step_ticks  <= STEP_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/dpwm_core.sv
`include "assert_macros.svh"

module dpwm_core
   import dpwm_pkg::*;
#(
   parameter int unsigned PWM_TOP = 100
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  dpwm_req_type item,
   input  dpwm_cfg_type cfg,
   output dpwm_rsp_type result
);

   localparam logic [7:0] TOP = 8'(PWM_TOP);

   logic [6:0] motor_count_ff, motor_count_in;
   logic [6:0] fan_count_ff, fan_count_in;
   logic [7:0] frame_count_ff, frame_count_in;
   logic [7:0] step_count_ff, step_count_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] goal_ff, goal_in;
   logic       motor_level_ff, motor_level_in;
   logic       fan_level_ff, fan_level_in;
   logic       servo_level_ff, servo_level_in;

   logic [7:0] motor_next;
   logic [7:0] fan_next;
   logic [8:0] frame_next;
   logic [8:0] step_next;

   always_comb begin
      motor_count_in = motor_count_ff;
      fan_count_in   = fan_count_ff;
      frame_count_in = frame_count_ff;
      step_count_in  = step_count_ff;
      pos_in         = pos_ff;
      goal_in        = goal_ff;
      motor_level_in = motor_level_ff;
      fan_level_in   = fan_level_ff;
      servo_level_in = servo_level_ff;

      motor_next = {1'b0, motor_count_ff} + 8'd1;
      fan_next   = {1'b0, fan_count_ff} + 8'd1;
      frame_next = {1'b0, frame_count_ff} + 9'd1;
      step_next  = {1'b0, step_count_ff} + 9'd1;

      if (fire && item.action) begin
         goal_in = item.target_value;
      end else if (fire) begin
         // low test first, restart wins on the same tick
         if (motor_next > {1'b0, cfg.motor_duty}) begin
            motor_level_in = 1'b0;
         end
         if (motor_next > TOP) begin
            motor_level_in = 1'b1;
            motor_next     = '0;
         end
         motor_count_in = motor_next[6:0];

         if (fan_next > {1'b0, cfg.fan_duty}) begin
            fan_level_in = 1'b0;
         end
         if (fan_next > TOP) begin
            fan_level_in = 1'b1;
            fan_next     = '0;
         end
         fan_count_in = fan_next[6:0];

         // servo compare sees the position from before the ramp move
         if (frame_next > {1'b0, pos_ff}) begin
            servo_level_in = 1'b0;
         end
         if (frame_next > {1'b0, cfg.frame_ticks}) begin
            servo_level_in = 1'b1;
            frame_next     = '0;
         end
         frame_count_in = frame_next[7:0];

         if (step_next > {1'b0, cfg.step_ticks}) begin
            step_next = '0;
            if (pos_ff > goal_ff) begin
               pos_in = pos_ff - 8'd1;
            end else if (pos_ff < goal_ff) begin
               pos_in = pos_ff + 8'd1;
            end
         end
         step_count_in = step_next[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_count_ff <= '0;
         fan_count_ff   <= '0;
         frame_count_ff <= '0;
         step_count_ff  <= '0;
         pos_ff         <= POS_RESET;
         goal_ff        <= '0;
         motor_level_ff <= 1'b0;
         fan_level_ff   <= 1'b0;
         servo_level_ff <= 1'b1;
      end else begin
         motor_count_ff <= motor_count_in;
         fan_count_ff   <= fan_count_in;
         frame_count_ff <= frame_count_in;
         step_count_ff  <= step_count_in;
         pos_ff         <= pos_in;
         goal_ff        <= goal_in;
         motor_level_ff <= motor_level_in;
         fan_level_ff   <= fan_level_in;
         servo_level_ff <= servo_level_in;
      end
   end

   always_comb begin
      result.motor_pin      = motor_level_in;
      result.fan_pin        = fan_level_in;
      result.servo_pin      = servo_level_in;
      result.servo_position = pos_in;
      result.servo_ready    = (pos_in == goal_in);
   end

   `ASSERT_ALWAYS(a_reset_counts, clock, reset |=> (motor_count_ff == '0 && frame_count_ff == '0), "counters not cleared by reset")
   `ASSERT_SYNC(a_idle_holds, clock, reset, !fire |=> ($stable(motor_count_ff) && $stable(step_count_ff) && $stable(pos_ff) && $stable(goal_ff)), "state moved without a transfer")
   `ASSERT_SYNC(a_target_no_tick, clock, reset, (fire && item.action) |=> ($stable(fan_count_ff) && $stable(frame_count_ff) && $stable(servo_level_ff)), "target load advanced the timers")
   `ASSERT_SYNC(a_ramp_one_unit, clock, reset, fire |=> (pos_ff == $past(pos_ff) || pos_ff == $past(pos_ff) + 8'd1 || pos_ff == $past(pos_ff) - 8'd1), "position moved more than one unit")

endmodule

// File: design/dual_pwm_and_ramped_servo_pulse_unit.sv
// motor and fan pwm plus a slew limited servo pulse, one item per cycle while rsp is not stalled
//
// req channel: req_valid / req_stall / req_payload. action 0 is one timer
// tick, action 1 loads target_value as the new servo goal.
// rsp channel: rsp_valid / rsp_stall / rsp_payload, exactly one result per
// item in order: the three pin levels, the ramped position and a ready flag.
// csr port: csr_wr_en, csr_index, csr_wdata; write only while idle.
//
// an item is taken into the input register, passes the compare and increment
// stage and its result is written into the result register. throughput is one
// item per cycle while rsp is not stalled, set by the single compare and
// increment stage between the input register and the result register.
//
// reset (synchronous): duties 1, frame 156, step 50, position 48, goal 0,
// motor and fan low, servo high, all counters zero, both channels empty.
// when the receiver stalls the result register holds, the input register
// keeps one more item, and then req_stall rises until rsp moves again.
module dual_pwm_and_ramped_servo_pulse_unit
   import dpwm_pkg::*;
#(
   parameter int unsigned PWM_TOP = 100
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dpwm_req_type           req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dpwm_rsp_type           rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic         s1_valid_ff, s1_valid_in;
   dpwm_req_type s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   dpwm_rsp_type rsp_payload_ff;
   dpwm_rsp_type core_result;
   dpwm_cfg_type cfg;
   logic         out_ready;
   logic         s1_ready;
   logic         fire;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_stall = !s1_ready;

   assign s1_valid_in  = s1_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_item_ff <= req_payload;
      end
      if (fire) begin
         rsp_payload_ff <= core_result;
      end
   end

   dpwm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dpwm_core #(
      .PWM_TOP (PWM_TOP)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: dv/tb_dual_pwm_and_ramped_servo_pulse_unit.sv
`timescale 1ns / 1ps

module tb_dual_pwm_and_ramped_servo_pulse_unit;
   import dpwm_pkg::*;

   localparam int unsigned PWM_TOP = 100;
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_LOAD = 1'b1;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned MAX_SHOWN = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dpwm_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dpwm_rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   dpwm_req_type req_backlog[$];
   dpwm_rsp_type pin_expect[$];
   logic req_fire = 1'b0;
   bit steady_flow = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   // predictor state
   dpwm_cfg_type model_cfg;
   logic [6:0] mot_cnt, fan_cnt;
   logic [7:0] frm_cnt, stp_cnt, pos_cur, pos_goal;
   logic mot_lvl, fan_lvl, srv_lvl;

   dual_pwm_and_ramped_servo_pulse_unit #(.PWM_TOP(PWM_TOP)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [6:0] clamp_duty(logic [6:0] v);
      if (v < DUTY_MIN) return DUTY_MIN;
      if (v > DUTY_MAX) return DUTY_MAX;
      return v;
   endfunction

   function automatic void pwm_advance(inout logic [6:0] cnt, inout logic lvl,
                                       input logic [6:0] duty);
      logic [7:0] nxt;
      nxt = {1'b0, cnt} + 8'd1;
      if (nxt > {1'b0, duty}) lvl = 1'b0;
      if (nxt > PWM_TOP) begin
         lvl = 1'b1;
         nxt = '0;
      end
      cnt = nxt[6:0];
   endfunction

   function automatic dpwm_rsp_type servo_pwm_next(dpwm_req_type it);
      logic [8:0] f;
      logic [8:0] s;
      dpwm_rsp_type r;
      if (it.action == ACT_LOAD) begin
         pos_goal = it.target_value;
      end else begin
         pwm_advance(mot_cnt, mot_lvl, model_cfg.motor_duty);
         pwm_advance(fan_cnt, fan_lvl, model_cfg.fan_duty);
         // servo compare sees the position before this tick's ramp move
         f = {1'b0, frm_cnt} + 9'd1;
         if (f > {1'b0, pos_cur}) srv_lvl = 1'b0;
         if (f > {1'b0, model_cfg.frame_ticks}) begin
            srv_lvl = 1'b1;
            f = '0;
         end
         frm_cnt = f[7:0];
         s = {1'b0, stp_cnt} + 9'd1;
         if (s > {1'b0, model_cfg.step_ticks}) begin
            s = '0;
            if (pos_cur > pos_goal) pos_cur = pos_cur - 8'd1;
            else if (pos_cur < pos_goal) pos_cur = pos_cur + 8'd1;
         end
         stp_cnt = s[7:0];
      end
      r.motor_pin = mot_lvl;
      r.fan_pin = fan_lvl;
      r.servo_pin = srv_lvl;
      r.servo_position = pos_cur;
      r.servo_ready = (pos_cur == pos_goal);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // stalled, payload held
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left = gap_left - 1;
      end else if (req_backlog.size() > 0) begin
         req_payload <= req_backlog.pop_front();
         req_valid <= 1'b1;
         gap_left = pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left = stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      dpwm_rsp_type want;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) pin_expect.push_back(servo_pwm_next(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (pin_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected result transfer: %p", rsp_payload);
            end else begin
               want = pin_expect.pop_front();
               if (rsp_payload.motor_pin !== want.motor_pin ||
                   rsp_payload.fan_pin !== want.fan_pin ||
                   rsp_payload.servo_pin !== want.servo_pin ||
                   rsp_payload.servo_position !== want.servo_position ||
                   rsp_payload.servo_ready !== want.servo_ready) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("mismatch at %0t: expected motor %b fan %b servo %b pos %0d rdy %b, got motor %b fan %b servo %b pos %0d rdy %b",
                              $realtime, want.motor_pin, want.fan_pin, want.servo_pin,
                              want.servo_position, want.servo_ready,
                              rsp_payload.motor_pin, rsp_payload.fan_pin,
                              rsp_payload.servo_pin, rsp_payload.servo_position,
                              rsp_payload.servo_ready);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[dual_pwm_and_ramped_servo_pulse_unit] ERROR");
            $finish;
         end
      end
   end

   task automatic model_reset();
      model_cfg.motor_duty = DUTY_RESET;
      model_cfg.fan_duty = DUTY_RESET;
      model_cfg.frame_ticks = FRAME_TICKS_RESET;
      model_cfg.step_ticks = STEP_TICKS_RESET;
      mot_cnt = '0;
      fan_cnt = '0;
      frm_cnt = '0;
      stp_cnt = '0;
      pos_cur = POS_RESET;
      pos_goal = '0;
      mot_lvl = 1'b0;
      fan_lvl = 1'b0;
      srv_lvl = 1'b1;
   endtask

   task automatic write_csr(dpwm_csr_index_type idx, logic [7:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MOTOR_DUTY: model_cfg.motor_duty = clamp_duty(v[6:0]);
         CSR_FAN_DUTY: model_cfg.fan_duty = clamp_duty(v[6:0]);
         CSR_FRAME_TICKS: model_cfg.frame_ticks = v;
         CSR_STEP_TICKS: model_cfg.step_ticks = v;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [7:0] motor, logic [7:0] fan, logic [7:0] frame,
                             logic [7:0] step);
      write_csr(CSR_MOTOR_DUTY, motor);
      write_csr(CSR_FAN_DUTY, fan);
      write_csr(CSR_FRAME_TICKS, frame);
      write_csr(CSR_STEP_TICKS, step);
   endtask

   // wait until every transfer has completed and all results are checked
   task automatic drain();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || pin_expect.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic queue_tick(int n, logic [7:0] tv = 8'h00, bit fixed = 1'b0);
      dpwm_req_type it;
      for (int i = 0; i < n; i++) begin
         it.action = ACT_TICK;
         it.target_value = fixed ? tv : 8'($urandom_range(0, 255));
         req_backlog.push_back(it);
      end
   endtask

   task automatic queue_load(logic [7:0] v);
      dpwm_req_type it;
      it.action = ACT_LOAD;
      it.target_value = v;
      req_backlog.push_back(it);
   endtask

   // target load followed by a run of ticks, now and then a long run
   task automatic queue_random(int n);
      int made;
      int run;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 9) < 7) queue_load(8'($urandom_range(30, 70)));
         else queue_load(8'($urandom_range(0, 255)));
         made++;
         if ($urandom_range(0, 9) < 8) run = $urandom_range(0, 40);
         else run = $urandom_range(100, 300);
         if (run > n - made) run = n - made;
         queue_tick(run);
         made += run;
      end
   endtask

   initial begin
      model_reset();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings: extreme targets, target equal to position, load without tick
      queue_tick(1, 8'hFF, 1'b1);
      queue_load(8'hFF);
      queue_tick(1, 8'h00, 1'b1);
      queue_load(8'h00);
      queue_load(POS_RESET);
      queue_tick(2);
      drain();

      // out-of-range duties, frame restarting and position moving on every tick
      set_config(8'h80, 8'h7F, 8'h00, 8'h00);
      queue_load(8'd52);
      queue_tick(5);
      queue_load(8'd50);
      queue_tick(3);
      queue_random(150);
      drain();

      // widest frame and step, no idling on either side
      steady_flow = 1'b1;
      set_config(8'd99, 8'h00, 8'hFF, 8'hFF);
      queue_random(250);
      drain();
      steady_flow = 1'b0;

      set_config(8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)),
                 8'($urandom_range(1, 254)), 8'($urandom_range(0, 6)));
      queue_random(200);
      drain();

      set_config(8'd100, 8'd2, 8'd1, 8'd1);
      queue_random(130);
      drain();

      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 3)));
      queue_random(180);
      drain();

      repeat (5) @(posedge clock);
      if (mismatches == 0 && pin_expect.size() == 0) begin
         $display("[dual_pwm_and_ramped_servo_pulse_unit] OK");
      end else begin
         $display("[dual_pwm_and_ramped_servo_pulse_unit] ERROR");
      end
      $finish;
   end

endmodule
